// ===== rtl/voxel_face_culling_unit_assert.svh =====
// assertion macros shared by the voxel face culling rtl
`ifndef VOXEL_FACE_CULLING_UNIT_ASSERT_SVH
`define VOXEL_FACE_CULLING_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define VFC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vfc same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define VFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vfc next-cycle check failed");

`endif

// ===== rtl/vfc_pkg.sv =====
// shared types and constants of the voxel face culling unit
package vfc_pkg;

  localparam int POS_XZ_W   = 4;
  localparam int POS_Y_W    = 7;
  localparam int CODE_W     = 8;
  localparam int FACE_W     = 3;
  localparam int WORLD_W    = 25;
  localparam int CHUNK_W    = 21;
  localparam int NP_W       = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int NUM_FACES  = 6;

  // neighbor_present bit positions
  localparam int NP_NORTH = 0;
  localparam int NP_SOUTH = 1;
  localparam int NP_EAST  = 2;
  localparam int NP_WEST  = 3;

  typedef enum logic [1:0] {
    OP_WR_VOXEL = 2'd0,
    OP_WR_EDGE  = 2'd1,
    OP_QUERY    = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    SIDE_NORTH = 2'd0,
    SIDE_SOUTH = 2'd1,
    SIDE_EAST  = 2'd2,
    SIDE_WEST  = 2'd3
  } side_t;

  typedef enum logic [FACE_W-1:0] {
    FACE_TOP    = 3'd0,
    FACE_BOTTOM = 3'd1,
    FACE_NORTH  = 3'd2,
    FACE_SOUTH  = 3'd3,
    FACE_EAST   = 3'd4,
    FACE_WEST   = 3'd5
  } face_t;

  typedef enum logic [2:0] {
    REG_CHUNK_X  = 3'd0,
    REG_CHUNK_Z  = 3'd1,
    REG_AIR      = 3'd2,
    REG_WATER    = 3'd3,
    REG_LEAVES   = 3'd4,
    REG_NEIGHBOR = 3'd5
  } reg_idx_t;

  // where a looked-up voxel comes from
  typedef enum logic [1:0] {
    SRC_AIR  = 2'd0,
    SRC_VOX  = 2'd1,
    SRC_EDGE = 2'd2
  } src_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_GATHER = 2'd1,
    ST_EVAL   = 2'd2,
    ST_EMIT   = 2'd3
  } state_t;

  // neighbor offsets per face: top, bottom, north, south, east, west
  localparam logic signed [1:0] STEP_DX [NUM_FACES] = '{2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1};
  localparam logic signed [1:0] STEP_DY [NUM_FACES] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0};
  localparam logic signed [1:0] STEP_DZ [NUM_FACES] = '{2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd0};

  // one lookup request to the address unit
  typedef struct packed {
    logic [POS_XZ_W-1:0] x;
    logic [POS_Y_W-1:0]  y;
    logic [POS_XZ_W-1:0] z;
    logic                center;
    face_t               face;
    logic                use_side;
    side_t               side;
  } addr_req_t;

endpackage

// ===== rtl/vfc_ram.sv =====
// generic single-port ram with registered read
module vfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/vfc_addr_gen.sv =====
// neighbor lookup and store address unit
module vfc_addr_gen
  import vfc_pkg::*;
#(
  parameter int SIZE_XZ = 16,
  parameter int SIZE_Y  = 128
) (
  input  addr_req_t                                req,
  input  logic [NP_W-1:0]                          neighbor_present,
  output src_t                                     src,
  output logic [$clog2(SIZE_XZ*SIZE_Y*SIZE_XZ)-1:0] vox_addr,
  output logic [$clog2(4*SIZE_XZ*SIZE_Y)-1:0]       edge_addr
);

  localparam int AXZ_W = $clog2(SIZE_XZ);
  localparam int AY_W  = $clog2(SIZE_Y);
  localparam int XZ_SW = ((POS_XZ_W > AXZ_W) ? POS_XZ_W : AXZ_W) + 2;
  localparam int Y_SW  = ((POS_Y_W > AY_W) ? POS_Y_W : AY_W) + 2;
  localparam int VA_W  = $clog2(SIZE_XZ*SIZE_Y*SIZE_XZ);
  localparam int EA_W  = $clog2(4*SIZE_XZ*SIZE_Y);

  logic signed [1:0]       dx, dy, dz;
  logic signed [XZ_SW-1:0] nx, nz, e_along;
  logic signed [Y_SW-1:0]  ny;
  side_t                   e_side;
  logic                    use_edge;
  logic                    cell_ok, edge_ok;

  always_comb begin
    dx = req.center ? 2'sd0 : STEP_DX[req.face];
    dy = req.center ? 2'sd0 : STEP_DY[req.face];
    dz = req.center ? 2'sd0 : STEP_DZ[req.face];
    nx = XZ_SW'($signed({1'b0, req.x})) + XZ_SW'(dx);
    ny = Y_SW'($signed({1'b0, req.y})) + Y_SW'(dy);
    nz = XZ_SW'($signed({1'b0, req.z})) + XZ_SW'(dz);
    e_side   = SIDE_NORTH;
    e_along  = nx;
    use_edge = 1'b0;
    // edge writes name the slice; reads across an edge go to a loaded neighbor
    priority if (req.use_side) begin
      e_side   = req.side;
      e_along  = (req.side == SIDE_NORTH || req.side == SIDE_SOUTH) ? nx : nz;
      use_edge = 1'b1;
    end else if (nx < 0 && neighbor_present[NP_WEST]) begin
      e_side   = SIDE_WEST;
      e_along  = nz;
      use_edge = 1'b1;
    end else if (nx >= SIZE_XZ && neighbor_present[NP_EAST]) begin
      e_side   = SIDE_EAST;
      e_along  = nz;
      use_edge = 1'b1;
    end else if (nz < 0 && neighbor_present[NP_NORTH]) begin
      e_side   = SIDE_NORTH;
      e_along  = nx;
      use_edge = 1'b1;
    end else if (nz >= SIZE_XZ && neighbor_present[NP_SOUTH]) begin
      e_side   = SIDE_SOUTH;
      e_along  = nx;
      use_edge = 1'b1;
    end else begin
      use_edge = 1'b0;
    end
    cell_ok = (nx >= 0) && (nx < SIZE_XZ) && (ny >= 0) && (ny < SIZE_Y) &&
              (nz >= 0) && (nz < SIZE_XZ);
    edge_ok = (e_along >= 0) && (e_along < SIZE_XZ) && (ny >= 0) && (ny < SIZE_Y);
    if (use_edge) begin
      src = edge_ok ? SRC_EDGE : SRC_AIR;
    end else begin
      src = cell_ok ? SRC_VOX : SRC_AIR;
    end
  end

  // (x * SIZE_Y + y) * SIZE_XZ + z
  assign vox_addr = VA_W'((VA_W'(nx[AXZ_W-1:0]) * VA_W'(SIZE_Y) + VA_W'(ny[AY_W-1:0]))
                          * VA_W'(SIZE_XZ) + VA_W'(nz[AXZ_W-1:0]));

  // (side * SIZE_XZ + along) * SIZE_Y + y
  assign edge_addr = EA_W'((EA_W'(e_side) * EA_W'(SIZE_XZ) + EA_W'(e_along[AXZ_W-1:0]))
                           * EA_W'(SIZE_Y) + EA_W'(ny[AY_W-1:0]));

endmodule

// ===== rtl/vfc_vis_unit.sv =====
// face visibility compare unit
module vfc_vis_unit #(
  parameter int CW = 8
) (
  input  logic [CW-1:0] bt,
  input  logic [CW-1:0] nb,
  input  logic [CW-1:0] air,
  input  logic [CW-1:0] water,
  input  logic [CW-1:0] leaves,
  output logic          show
);

  // an air voxel shows nothing
  assign show = (bt != air) &&
                ((nb == air) ||
                 (bt != water && nb == water) ||
                 (bt != leaves && nb == leaves));

endmodule

// ===== rtl/voxel_face_culling_unit.sv =====
// top level of the voxel face culling unit
//
// Holds one chunk of voxel type codes in a single-port voxel ram and the facing
// edge slices of the four horizontal neighbor chunks in a single-port edge ram.
// Input transfers with opcode write-voxel or write-edge store one code and give
// no result; writes outside the chunk are dropped. A query takes the block out
// of the ready state: one shared address unit walks the voxel and its six
// neighbors, one ram read per cycle, and one shared compare unit builds a
// visibility mask as the reads come back. The records then leave one per cycle
// through the output register while the output is not stalled, in the order
// top, bottom, north, south, east, west, with last set on the final one; an air
// voxel or one with no visible face gives a single empty record. Neither ram is
// cleared after reset: entries must be written before they are read.
// Configuration registers sit on an apb-style port at byte address 4*index and
// must be written only while the block is idle.
module voxel_face_culling_unit
  import vfc_pkg::*;
#(
  parameter int SIZE_XZ   = 16,
  parameter int SIZE_Y    = 128,
  parameter int TYPE_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_opcode,
  input  logic [POS_XZ_W-1:0]       in_pos_x,
  input  logic [POS_Y_W-1:0]        in_pos_y,
  input  logic [POS_XZ_W-1:0]       in_pos_z,
  input  logic [1:0]                in_side,
  input  logic [CODE_W-1:0]         in_type_in,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_face_valid,
  output logic [FACE_W-1:0]         out_face,
  output logic signed [WORLD_W-1:0] out_world_x,
  output logic [POS_Y_W-1:0]        out_world_y,
  output logic signed [WORLD_W-1:0] out_world_z,
  output logic [CODE_W-1:0]         out_type_out,
  output logic                      out_last,
  // configuration port
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [CFG_DATA_W-1:0]     cfg_prdata,
  output logic                      cfg_pready
);

  // compare width covers both stored codes and register codes
  localparam int CW   = (TYPE_BITS > CODE_W) ? TYPE_BITS : CODE_W;
  localparam int VA_W = $clog2(SIZE_XZ*SIZE_Y*SIZE_XZ);
  localparam int EA_W = $clog2(4*SIZE_XZ*SIZE_Y);

  // configuration registers
  logic signed [CHUNK_W-1:0] cfg_chunk_x_r, cfg_chunk_z_r;
  logic [CODE_W-1:0]         cfg_air_r, cfg_water_r, cfg_leaves_r;
  logic [NP_W-1:0]           cfg_np_r;
  logic                      cfg_wr;
  logic [2:0]                cfg_idx;

  // sequencer
  state_t               state_r, state_nxt;
  logic [2:0]           step_r, step_nxt;
  logic [NUM_FACES-1:0] mask_r, mask_nxt;
  logic [CW-1:0]        bt_r, bt_nxt;
  src_t                 src_q_r;

  // latched query
  logic [POS_XZ_W-1:0]       qx_r, qz_r;
  logic [POS_Y_W-1:0]        qy_r;
  logic signed [WORLD_W-1:0] wx_r, wz_r, wx_nxt, wz_nxt;
  logic signed [WORLD_W-1:0] cx_ext, cz_ext;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_face_valid_r, out_last_r;
  logic [FACE_W-1:0]         out_face_r;
  logic signed [WORLD_W-1:0] out_world_x_r, out_world_z_r;
  logic [POS_Y_W-1:0]        out_world_y_r;
  logic [CODE_W-1:0]         out_type_r;
  logic                      out_load;
  logic                      rec_face_valid, rec_last;
  logic [FACE_W-1:0]         rec_face;

  // datapath wires
  addr_req_t           areq;
  src_t                asrc;
  logic [VA_W-1:0]     vox_addr;
  logic [EA_W-1:0]     edge_addr;
  logic                in_accept;
  logic                vox_we, vox_re, edge_we, edge_re;
  logic [TYPE_BITS-1:0] wdata, vox_rdata, edge_rdata;
  logic [CW-1:0]       nb_val, air_ext, water_ext, leaves_ext;
  logic                show;
  logic                eval_en;
  logic [FACE_W-1:0]   eval_face;
  logic                load_ok;
  logic                found;
  logic [FACE_W-1:0]   sel_face;
  logic [NUM_FACES-1:0] mask_clr;

  // ---------------------------------------------------------------------
  // configuration port: one write per access phase, reads are a plain mux
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_chunk_x_r <= '0;
      cfg_chunk_z_r <= '0;
      cfg_air_r     <= CODE_W'(0);
      cfg_water_r   <= CODE_W'(1);
      cfg_leaves_r  <= CODE_W'(2);
      cfg_np_r      <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CHUNK_X:  cfg_chunk_x_r <= cfg_pwdata[CHUNK_W-1:0];
        REG_CHUNK_Z:  cfg_chunk_z_r <= cfg_pwdata[CHUNK_W-1:0];
        REG_AIR:      cfg_air_r     <= cfg_pwdata[CODE_W-1:0];
        REG_WATER:    cfg_water_r   <= cfg_pwdata[CODE_W-1:0];
        REG_LEAVES:   cfg_leaves_r  <= cfg_pwdata[CODE_W-1:0];
        REG_NEIGHBOR: cfg_np_r      <= cfg_pwdata[NP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CHUNK_X:  cfg_prdata = CFG_DATA_W'(cfg_chunk_x_r);
      REG_CHUNK_Z:  cfg_prdata = CFG_DATA_W'(cfg_chunk_z_r);
      REG_AIR:      cfg_prdata = CFG_DATA_W'(cfg_air_r);
      REG_WATER:    cfg_prdata = CFG_DATA_W'(cfg_water_r);
      REG_LEAVES:   cfg_prdata = CFG_DATA_W'(cfg_leaves_r);
      REG_NEIGHBOR: cfg_prdata = CFG_DATA_W'(cfg_np_r);
      default:      cfg_prdata = '0;
    endcase
  end

  assign air_ext    = CW'(cfg_air_r);
  assign water_ext  = CW'(cfg_water_r);
  assign leaves_ext = CW'(cfg_leaves_r);

  // ---------------------------------------------------------------------
  // input side: only the idle state takes a transfer
  // ---------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // world coordinates: chunk * SIZE_XZ + local, wrapping at 25 bits
  assign cx_ext = WORLD_W'(cfg_chunk_x_r);
  assign cz_ext = WORLD_W'(cfg_chunk_z_r);
  assign wx_nxt = WORLD_W'(cx_ext * WORLD_W'(SIZE_XZ) + WORLD_W'(in_pos_x));
  assign wz_nxt = WORLD_W'(cz_ext * WORLD_W'(SIZE_XZ) + WORLD_W'(in_pos_z));

  // the address unit serves writes while idle and the lookup walk otherwise
  always_comb begin
    if (state_r == ST_IDLE) begin
      areq.x        = in_pos_x;
      areq.y        = in_pos_y;
      areq.z        = in_pos_z;
      areq.center   = 1'b1;
      areq.face     = FACE_TOP;
      areq.use_side = (in_opcode == OP_WR_EDGE);
      areq.side     = side_t'(in_side);
    end else begin
      areq.x        = qx_r;
      areq.y        = qy_r;
      areq.z        = qz_r;
      // outside the walk the lookup parks on the center voxel
      areq.center   = (step_r == 3'd0) || (state_r != ST_GATHER);
      areq.face     = face_t'(step_r - 3'd1);
      areq.use_side = 1'b0;
      areq.side     = SIDE_NORTH;
    end
  end

  vfc_addr_gen #(
    .SIZE_XZ (SIZE_XZ),
    .SIZE_Y  (SIZE_Y)
  ) u_addr_gen (
    .req              (areq),
    .neighbor_present (cfg_np_r),
    .src              (asrc),
    .vox_addr         (vox_addr),
    .edge_addr        (edge_addr)
  );

  // writes out of range come back as air source and are dropped
  assign wdata   = TYPE_BITS'(in_type_in);
  assign vox_we  = in_accept && (in_opcode == OP_WR_VOXEL) && (asrc == SRC_VOX);
  assign edge_we = in_accept && (in_opcode == OP_WR_EDGE) && (asrc == SRC_EDGE);
  assign vox_re  = (state_r == ST_GATHER) && (asrc == SRC_VOX);
  assign edge_re = (state_r == ST_GATHER) && (asrc == SRC_EDGE);

  vfc_ram #(
    .WIDTH (TYPE_BITS),
    .DEPTH (SIZE_XZ*SIZE_Y*SIZE_XZ)
  ) u_voxel_ram (
    .clk   (clk),
    .we    (vox_we),
    .re    (vox_re),
    .addr  (vox_addr),
    .wdata (wdata),
    .rdata (vox_rdata)
  );

  vfc_ram #(
    .WIDTH (TYPE_BITS),
    .DEPTH (4*SIZE_XZ*SIZE_Y)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .re    (edge_re),
    .addr  (edge_addr),
    .wdata (wdata),
    .rdata (edge_rdata)
  );

  // ---------------------------------------------------------------------
  // evaluation: the read issued last cycle comes back now
  // ---------------------------------------------------------------------
  always_comb begin
    unique case (src_q_r)
      SRC_VOX:  nb_val = CW'(vox_rdata);
      SRC_EDGE: nb_val = CW'(edge_rdata);
      default:  nb_val = air_ext;
    endcase
  end

  vfc_vis_unit #(
    .CW (CW)
  ) u_vis_unit (
    .bt     (bt_r),
    .nb     (nb_val),
    .air    (air_ext),
    .water  (water_ext),
    .leaves (leaves_ext),
    .show   (show)
  );

  // step 1 returns the center, steps 2..6 and the eval state return faces
  assign eval_en   = ((state_r == ST_GATHER) && (step_r >= 3'd2)) || (state_r == ST_EVAL);
  assign eval_face = (state_r == ST_EVAL) ? FACE_W'(NUM_FACES - 1) : (step_r - 3'd2);

  // ---------------------------------------------------------------------
  // emission: lowest pending face first
  // ---------------------------------------------------------------------
  always_comb begin
    found    = 1'b0;
    sel_face = FACE_TOP;
    for (int i = 0; i < NUM_FACES; i++) begin
      if (mask_r[i] && !found) begin
        found    = 1'b1;
        sel_face = FACE_W'(i);
      end
    end
    mask_clr = mask_r & ~(NUM_FACES'(1) << sel_face);
  end

  assign load_ok        = !out_valid_r || !out_stall;
  assign rec_face_valid = found;
  assign rec_face       = found ? sel_face : FACE_TOP;
  assign rec_last       = !found || (mask_clr == '0);

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    mask_nxt      = mask_r;
    bt_nxt        = bt_r;
    out_load      = 1'b0;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    if (eval_en) begin
      for (int i = 0; i < NUM_FACES; i++) begin
        if (eval_face == FACE_W'(i)) begin
          mask_nxt[i] = show;
        end
      end
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && in_opcode == OP_QUERY) begin
          state_nxt = ST_GATHER;
          step_nxt  = 3'd0;
          mask_nxt  = '0;
        end
      end
      ST_GATHER: begin
        if (step_r == 3'd1) begin
          bt_nxt = nb_val;
        end
        step_nxt = step_r + 3'd1;
        if (step_r == 3'(NUM_FACES)) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load_ok) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          mask_nxt      = mask_clr;
          if (rec_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    mask_r  <= mask_nxt;
    bt_r    <= bt_nxt;
    src_q_r <= asrc;
    if (in_accept) begin
      qx_r <= in_pos_x;
      qy_r <= in_pos_y;
      qz_r <= in_pos_z;
      wx_r <= wx_nxt;
      wz_r <= wz_nxt;
    end
    if (out_load) begin
      out_face_valid_r <= rec_face_valid;
      out_face_r       <= rec_face;
      out_world_x_r    <= wx_r;
      out_world_y_r    <= qy_r;
      out_world_z_r    <= wz_r;
      out_type_r       <= bt_r[CODE_W-1:0];
      out_last_r       <= rec_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_face_valid = out_face_valid_r;
  assign out_face       = out_face_r;
  assign out_world_x    = out_world_x_r;
  assign out_world_y    = out_world_y_r;
  assign out_world_z    = out_world_z_r;
  assign out_type_out   = out_type_r;
  assign out_last       = out_last_r;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
`include "voxel_face_culling_unit_assert.svh"

  // a query starts the walk at the center voxel
  `VFC_ASSERT_NEXT(a_query_starts_walk, in_accept && in_opcode == OP_QUERY, state_r == ST_GATHER && step_r == 3'd0)
  // an empty record always closes its query
  `VFC_ASSERT_SAME(a_empty_is_last, out_valid && !out_face_valid, out_last)
  // an air voxel never leaves a visible face pending
  `VFC_ASSERT_SAME(a_air_no_faces, state_r == ST_EMIT && bt_r == air_ext, mask_r == '0)
  // visible records carry a real face code
  `VFC_ASSERT_SAME(a_face_code_ok, out_valid && out_face_valid, out_face <= FACE_WEST)

endmodule
